FILE: rtl/failure_count_blocker_top_assert.svh
// Assertion macros shared by the checker of the failure count blocker.
`ifndef FAILURE_COUNT_BLOCKER_TOP_ASSERT_SVH
`define FAILURE_COUNT_BLOCKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("failure count blocker: implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define FCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("failure count blocker: next-cycle implication violated");

`endif

FILE: rtl/fcb_pkg.sv
`default_nettype none

package fcb_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 64;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned MAX_FAILS_W = 7;
    localparam int unsigned EXPIRE_W    = 17;
    localparam int unsigned COUNT_W     = 7;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [COUNT_W-1:0]     COUNT_MAX      = 7'd127;
    localparam logic [MAX_FAILS_W-1:0] DEF_MAX_FAILS  = 7'd8;
    localparam logic [EXPIRE_W-1:0]    DEF_EXPIRE_SEC = 17'd5;

    // Opcodes of a command beat.
    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_SWEEP  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FAILS   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPIRE_SEC  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KILL_STATES = 8'd2;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } fcb_state_t;

    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] src_addr;
        logic [TIME_W-1:0] now_seconds;
    } fcb_cmd_t;

    typedef struct packed {
        logic               block_now;
        logic [ADDR_W-1:0]  block_addr;
        logic               kill_req;
        logic               full_drop;
        logic [COUNT_W-1:0] fail_count;
        logic [COUNT_W-1:0] expired_count;
    } fcb_result_t;

    // Command context broadcast to every cell during a walk.
    typedef struct packed {
        logic                   opcode;
        logic [ADDR_W-1:0]      addr;
        logic [TIME_W-1:0]      now;
        logic [MAX_FAILS_W-1:0] max_fails;
        logic [EXPIRE_W-1:0]    expire_seconds;
    } fcb_ctx_t;

    // Token handed from cell to cell, accumulating the outcome of the walk.
    typedef struct packed {
        logic               active;
        logic               found;
        logic               blk;
        logic [COUNT_W-1:0] cnt;
        logic               free_seen;
        logic [COUNT_W-1:0] freed;
    } fcb_carry_t;

endpackage

`default_nettype wire

FILE: rtl/failure_count_blocker_top.sv
// A report or sweep walks a token through all TABLE_ENTRIES cells, one cell
// per cycle; done is registered and rises once the token leaves the last cell.
// A report that blocks at once (max_fails of 0 or 1) answers without a walk.
// A walk holds busy until it ends, so no new command is taken during it; immediate blocks, one per cycle.
// The receiver cannot stall: each result is shown for one cycle with done.
// Reset (rst_n low, asynchronous) empties the table and loads default registers.
`default_nettype none

module failure_count_blocker_top #(
    parameter int unsigned TABLE_ENTRIES = fcb_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire fcb_pkg::fcb_cmd_t              cmd,
    output logic                                done,
    output fcb_pkg::fcb_result_t                result,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [fcb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [fcb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    fcb_pkg::fcb_state_t                   state_reg;
    fcb_pkg::fcb_state_t                   state_next;
    fcb_pkg::fcb_cmd_t                     cmd_reg;
    logic [fcb_pkg::MAX_FAILS_W-1:0]       max_fails_reg;
    logic [fcb_pkg::EXPIRE_W-1:0]          expire_reg;
    logic                                  kill_reg;
    logic                                  inject_reg;
    logic                                  inject_next;
    logic                                  done_reg;
    logic                                  done_next;
    fcb_pkg::fcb_result_t                  result_reg;
    fcb_pkg::fcb_result_t                  result_next;

    logic                                  accept;
    logic                                  immediate;
    logic                                  ins_en;
    fcb_pkg::fcb_ctx_t                     ctx;
    fcb_pkg::fcb_carry_t                   carry [0:TABLE_ENTRIES];
    fcb_pkg::fcb_carry_t                   tail;

    assign busy      = (state_reg != fcb_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign immediate = (cmd.opcode == fcb_pkg::OP_REPORT) && (max_fails_reg <= 7'd1);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;
    assign tail      = carry[TABLE_ENTRIES];

    always_comb
    begin
        ctx.opcode         = cmd_reg.opcode;
        ctx.addr           = cmd_reg.src_addr;
        ctx.now            = cmd_reg.now_seconds;
        ctx.max_fails      = max_fails_reg;
        ctx.expire_seconds = expire_reg;

        carry[0]        = '0;
        carry[0].active = inject_reg;
    end

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        fcb_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctx       (ctx),
            .ins_en    (ins_en),
            .carry_in  (carry[i]),
            .carry_out (carry[i+1])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        inject_next = 1'b0;
        done_next   = 1'b0;
        ins_en      = 1'b0;
        result_next = result_reg;
        case (state_reg)
            fcb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (immediate)
                    begin
                        result_next            = '0;
                        result_next.block_now  = 1'b1;
                        result_next.block_addr = cmd.src_addr;
                        result_next.kill_req   = kill_reg;
                        result_next.fail_count = 7'd1;
                        done_next              = 1'b1;
                    end
                    else
                    begin
                        state_next  = fcb_pkg::ST_WALK;
                        inject_next = 1'b1;
                    end
                end
            end
            fcb_pkg::ST_WALK:
            begin
                if (tail.active)
                begin
                    state_next  = fcb_pkg::ST_IDLE;
                    done_next   = 1'b1;
                    result_next = '0;
                    if (cmd_reg.opcode == fcb_pkg::OP_SWEEP)
                    begin
                        result_next.expired_count = tail.freed;
                    end
                    else if (tail.found)
                    begin
                        result_next.fail_count = tail.cnt;
                        if (tail.blk)
                        begin
                            result_next.block_now  = 1'b1;
                            result_next.block_addr = cmd_reg.src_addr;
                            result_next.kill_req   = kill_reg;
                        end
                    end
                    else if (tail.free_seen)
                    begin
                        // The lowest free cell claimed itself during the walk.
                        ins_en                 = 1'b1;
                        result_next.fail_count = 7'd1;
                    end
                    else
                    begin
                        result_next.full_drop = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = fcb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fcb_pkg::ST_IDLE;
            inject_reg    <= 1'b0;
            done_reg      <= 1'b0;
            max_fails_reg <= fcb_pkg::DEF_MAX_FAILS;
            expire_reg    <= fcb_pkg::DEF_EXPIRE_SEC;
            kill_reg      <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            inject_reg <= inject_next;
            done_reg   <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fcb_pkg::CFG_MAX_FAILS:   max_fails_reg <= cfg_data[fcb_pkg::MAX_FAILS_W-1:0];
                    fcb_pkg::CFG_EXPIRE_SEC:  expire_reg    <= cfg_data[fcb_pkg::EXPIRE_W-1:0];
                    fcb_pkg::CFG_KILL_STATES: kill_reg      <= cfg_data[0];
                    default:                  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

FILE: rtl/fcb_cell.sv
`default_nettype none

module fcb_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fcb_pkg::fcb_ctx_t  ctx,
    input  wire logic               ins_en,
    input  wire fcb_pkg::fcb_carry_t carry_in,
    output fcb_pkg::fcb_carry_t     carry_out
);

    logic                                valid_reg;
    logic                                valid_next;
    logic                                claim_reg;
    logic                                claim_next;
    logic [fcb_pkg::ADDR_W-1:0]          addr_reg;
    logic [fcb_pkg::ADDR_W-1:0]          addr_next;
    logic [fcb_pkg::TIME_W-1:0]          first_reg;
    logic [fcb_pkg::TIME_W-1:0]          first_next;
    logic [fcb_pkg::COUNT_W-1:0]         count_reg;
    logic [fcb_pkg::COUNT_W-1:0]         count_next;
    fcb_pkg::fcb_carry_t                 carry_reg;
    fcb_pkg::fcb_carry_t                 carry_next;

    logic [fcb_pkg::TIME_W-1:0]          age;
    logic [fcb_pkg::COUNT_W-1:0]         count_inc;
    logic                                is_report;
    logic                                hit;
    logic                                reach;
    logic                                stale;

    always_comb
    begin
        is_report = (ctx.opcode == fcb_pkg::OP_REPORT);
        // Age is taken modulo 2^32 so a wrapped clock still works.
        age       = ctx.now - first_reg;
        count_inc = (count_reg == fcb_pkg::COUNT_MAX) ? count_reg
                                                      : count_reg + 7'd1;
        reach     = (count_inc >= ctx.max_fails);
        hit       = carry_in.active && is_report && valid_reg && !carry_in.found
                    && (addr_reg == ctx.addr);
        stale     = carry_in.active && !is_report && valid_reg
                    && (age > {{(fcb_pkg::TIME_W-fcb_pkg::EXPIRE_W){1'b0}},
                               ctx.expire_seconds});

        carry_next = carry_in;
        if (hit)
        begin
            carry_next.found = 1'b1;
            carry_next.cnt   = count_inc;
            carry_next.blk   = reach;
        end
        if (stale && (carry_in.freed != fcb_pkg::COUNT_MAX))
        begin
            carry_next.freed = carry_in.freed + 7'd1;
        end
        if (carry_in.active && is_report && !valid_reg)
        begin
            carry_next.free_seen = 1'b1;
        end

        // The first free cell of a report walk marks itself for a possible insert.
        claim_next = claim_reg;
        if (carry_in.active)
        begin
            claim_next = is_report && !valid_reg && !carry_in.free_seen;
        end

        valid_next = valid_reg;
        addr_next  = addr_reg;
        first_next = first_reg;
        count_next = count_reg;
        if (hit)
        begin
            count_next = count_inc;
            if (reach)
            begin
                valid_next = 1'b0;
            end
        end
        if (stale)
        begin
            valid_next = 1'b0;
        end
        if (ins_en && claim_reg)
        begin
            valid_next = 1'b1;
            addr_next  = ctx.addr;
            first_next = ctx.now;
            count_next = 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            claim_reg <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            claim_reg <= claim_next;
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        first_reg <= first_next;
        count_reg <= count_next;
    end

    assign carry_out = carry_reg;

endmodule

`default_nettype wire

FILE: rtl/fcb_checker.sv
`default_nettype none

`include "failure_count_blocker_top_assert.svh"

module fcb_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic                 done,
    input  wire fcb_pkg::fcb_result_t result
);

    // A result beat is only shown once the block is free for the next command.
    `FCB_ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy)

    // An accepted command either starts a walk or answers at once.
    `FCB_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || done)

    // Block fields are quiet unless a block is requested.
    `FCB_ASSERT_IMPLY(a_block_quiet, clk, rst_n, done && !result.block_now,
        (result.block_addr == 32'd0) && !result.kill_req)

    // A sweep result carries no report outcome.
    `FCB_ASSERT_IMPLY(a_sweep_clean, clk, rst_n, done && (result.expired_count != 7'd0),
        (result.fail_count == 7'd0) && !result.block_now && !result.full_drop)

endmodule

bind failure_count_blocker_top fcb_checker u_fcb_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import fcb_pkg::*;

    localparam int unsigned SLOTS      = TABLE_ENTRIES_DEF;
    localparam int unsigned QUIET_WAIT = 4;
    localparam int unsigned HANG_LIMIT = 4000;
    localparam int unsigned RUN_ITEMS  = 900;

    typedef enum logic [1:0] {
        ACT_CMD,
        ACT_REG,
        ACT_PAUSE
    } act_kind_t;

    typedef struct packed {
        act_kind_t              kind;
        fcb_cmd_t               cmd;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
    } work_item_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    fcb_cmd_t               cmd = '0;
    logic                   done;
    fcb_result_t            result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    work_item_t  work_q[$];
    fcb_result_t verdict_q[$];
    int unsigned mismatches = 0;

    // Local copy of the registers and the address table.
    logic [MAX_FAILS_W-1:0] lim_fails = DEF_MAX_FAILS;
    logic [EXPIRE_W-1:0]    lim_age = DEF_EXPIRE_SEC;
    logic                   kill_on_block = 1'b0;
    logic                   tbl_used [SLOTS];
    logic [ADDR_W-1:0]      tbl_addr [SLOTS];
    logic [TIME_W-1:0]      tbl_since [SLOTS];
    logic [COUNT_W-1:0]     tbl_hits [SLOTS];

    int unsigned gap_left = 0;
    int unsigned burst_left = 1;
    int unsigned quiet_cnt = 0;
    int unsigned idle_cycles = 0;

    failure_count_blocker_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_used[i] = 1'b0;
        end
    end

    function automatic fcb_result_t tally_attempt(fcb_cmd_t c);
        fcb_result_t        r;
        logic [TIME_W-1:0]  age;
        logic [COUNT_W-1:0] n;
        int                 hit;
        int                 hole;
        r = '0;
        hit = -1;
        hole = -1;
        if (c.opcode == OP_SWEEP)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (tbl_used[i])
                begin
                    age = c.now_seconds - tbl_since[i];
                    if (age > TIME_W'(lim_age))
                    begin
                        tbl_used[i] = 1'b0;
                        if (r.expired_count != COUNT_MAX)
                        begin
                            r.expired_count = r.expired_count + COUNT_W'(1);
                        end
                    end
                end
            end
        end
        else if (lim_fails <= MAX_FAILS_W'(1))
        begin
            // A threshold of one (or zero) blocks without touching the table.
            r.block_now = 1'b1;
            r.block_addr = c.src_addr;
            r.kill_req = kill_on_block;
            r.fail_count = COUNT_W'(1);
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (tbl_used[i] && tbl_addr[i] == c.src_addr && hit < 0)
                begin
                    hit = i;
                end
                if (!tbl_used[i] && hole < 0)
                begin
                    hole = i;
                end
            end
            if (hit >= 0)
            begin
                n = tbl_hits[hit];
                if (n != COUNT_MAX)
                begin
                    n = n + COUNT_W'(1);
                end
                tbl_hits[hit] = n;
                r.fail_count = n;
                if (n >= COUNT_W'(lim_fails))
                begin
                    r.block_now = 1'b1;
                    r.block_addr = c.src_addr;
                    r.kill_req = kill_on_block;
                    tbl_used[hit] = 1'b0;
                end
            end
            else if (hole >= 0)
            begin
                tbl_used[hole] = 1'b1;
                tbl_addr[hole] = c.src_addr;
                tbl_since[hole] = c.now_seconds;
                tbl_hits[hole] = COUNT_W'(1);
                r.fail_count = COUNT_W'(1);
            end
            else
            begin
                r.full_drop = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic push_report(input logic [ADDR_W-1:0] a, input logic [TIME_W-1:0] t);
        work_item_t w;
        w = '0;
        w.kind = ACT_CMD;
        w.cmd.opcode = OP_REPORT;
        w.cmd.src_addr = a;
        w.cmd.now_seconds = t;
        work_q.push_back(w);
    endtask

    task automatic push_sweep(input logic [TIME_W-1:0] t);
        work_item_t w;
        w = '0;
        w.kind = ACT_CMD;
        w.cmd.opcode = OP_SWEEP;
        w.cmd.src_addr = $urandom();
        w.cmd.now_seconds = t;
        work_q.push_back(w);
    endtask

    task automatic push_reg(input logic [CFG_INDEX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
        work_item_t w;
        w = '0;
        w.kind = ACT_REG;
        w.idx = idx;
        w.data = data;
        work_q.push_back(w);
    endtask

    task automatic push_pause();
        work_item_t w;
        w = '0;
        w.kind = ACT_PAUSE;
        work_q.push_back(w);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Driver: commands go out in bursts, register writes only while the block is idle.
    always @(posedge clk)
    begin : driver
        logic nxt_start;
        logic nxt_cfg;
        if (rst_n)
        begin
            nxt_start = start;
            nxt_cfg = cfg_valid;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            if (verdict_q.size() == 0 && !busy && !start && !done && !cfg_valid)
            begin
                quiet_cnt++;
            end
            else
            begin
                quiet_cnt = 0;
            end
            if (start && !busy)
            begin
                verdict_q.push_back(tally_attempt(work_q[0].cmd));
                void'(work_q.pop_front());
                nxt_start = 1'b0;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8);
                    gap_left = $urandom_range(1, 100);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (work_q[0].idx)
                    CFG_MAX_FAILS:   lim_fails = work_q[0].data[MAX_FAILS_W-1:0];
                    CFG_EXPIRE_SEC:  lim_age = work_q[0].data[EXPIRE_W-1:0];
                    CFG_KILL_STATES: kill_on_block = work_q[0].data[0];
                    default:         ;
                endcase
                void'(work_q.pop_front());
                nxt_cfg = 1'b0;
                quiet_cnt = 0;
            end
            if (!nxt_start && !nxt_cfg && work_q.size() != 0)
            begin
                case (work_q[0].kind)
                    ACT_CMD:
                    begin
                        if (gap_left == 0)
                        begin
                            nxt_start = 1'b1;
                            cmd <= work_q[0].cmd;
                        end
                    end
                    ACT_REG:
                    begin
                        if (quiet_cnt >= QUIET_WAIT)
                        begin
                            nxt_cfg = 1'b1;
                            cfg_index <= work_q[0].idx;
                            cfg_data <= work_q[0].data;
                        end
                    end
                    default:
                    begin
                        if (quiet_cnt >= QUIET_WAIT)
                        begin
                            void'(work_q.pop_front());
                        end
                    end
                endcase
            end
            start <= nxt_start;
            cfg_valid <= nxt_cfg;
        end
    end

    // Monitor: every done beat is matched against the oldest pending verdict.
    always @(posedge clk)
    begin : monitor
        fcb_result_t want;
        if (rst_n && done)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: result with none pending, expected none, actual %p",
                         $time, result);
                mismatches++;
            end
            else
            begin
                want = verdict_q.pop_front();
                check_field("block_now", 32'(want.block_now), 32'(result.block_now));
                check_field("block_addr", want.block_addr, result.block_addr);
                check_field("kill_req", 32'(want.kill_req), 32'(result.kill_req));
                check_field("full_drop", 32'(want.full_drop), 32'(result.full_drop));
                check_field("fail_count", 32'(want.fail_count), 32'(result.fail_count));
                check_field("expired_count", 32'(want.expired_count),
                            32'(result.expired_count));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((start && !busy) || (cfg_valid && cfg_ready) || done)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [ADDR_W-1:0] pool [70];
        logic [TIME_W-1:0] now_s;
        int unsigned       total;
        int unsigned       pool_n;
        int unsigned       mf;
        int unsigned       age_s;
        int unsigned       len;
        int unsigned       pick;

        // Address and time extremes; the sweep at 5 frees only the entry whose
        // age wrapped past zero.
        push_report(32'h0000_0000, 32'h0000_0000);
        push_report(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_report(32'h0000_0000, 32'h0000_0003);
        push_sweep(32'h0000_0005);
        push_sweep(32'hFFFF_FFFF);

        // Immediate block with thresholds of one and zero; upper data bits are dropped.
        push_pause();
        push_reg(CFG_MAX_FAILS, 32'hFFFF_FF81);
        push_reg(CFG_KILL_STATES, 32'hFFFF_FFFF);
        push_report(32'h1234_5678, 32'd10);
        push_pause();
        push_reg(CFG_MAX_FAILS, 32'h0000_0080);
        push_report(32'hA5A5_A5A5, 32'd11);

        // Normal counting up to a block, then a threshold lowered to a live count.
        push_pause();
        push_reg(CFG_MAX_FAILS, 32'd3);
        push_reg(CFG_KILL_STATES, 32'hFFFF_FFFE);
        push_reg(CFG_EXPIRE_SEC, 32'hFFFF_FFFF);
        push_reg(8'hFF, 32'hFFFF_FFFF);
        push_reg(8'h03, 32'h0000_0001);
        push_report(32'h0A00_0001, 32'd20);
        push_report(32'h0A00_0001, 32'd21);
        push_report(32'h0A00_0001, 32'd22);
        push_report(32'h0A00_0002, 32'd23);
        push_report(32'h0A00_0002, 32'd24);
        push_pause();
        push_reg(CFG_MAX_FAILS, 32'd2);
        push_report(32'h0A00_0002, 32'd25);

        // Age right at the limit stays, one second more is freed.
        push_report(32'h0A00_0003, 32'd30);
        push_sweep(32'd30 + 32'd131071);
        push_sweep(32'd30 + 32'd131072);

        total = 0;
        while (total < RUN_ITEMS)
        begin
            push_pause();
            case ($urandom_range(0, 3))
                0:       pool_n = 1;
                1:       pool_n = 4;
                2:       pool_n = 16;
                default: pool_n = 70;
            endcase
            if (pool_n == 70)
            begin
                // Enough distinct addresses to fill the table before any blocks.
                mf = 100;
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0:       mf = 0;
                    1:       mf = 1;
                    2:       mf = 2;
                    3:       mf = 100;
                    4:       mf = 127;
                    default: mf = $urandom_range(2, 12);
                endcase
            end
            case ($urandom_range(0, 5))
                0:       age_s = 1;
                1:       age_s = 131071;
                2:       age_s = $urandom_range(1, 86400);
                default: age_s = $urandom_range(1, 40);
            endcase
            push_reg(CFG_MAX_FAILS, ($urandom() & 32'hFFFF_FF80) | mf);
            push_reg(CFG_EXPIRE_SEC, ($urandom() & 32'hFFFE_0000) | age_s);
            push_reg(CFG_KILL_STATES, $urandom());
            if ($urandom_range(0, 3) == 0)
            begin
                push_reg(CFG_INDEX_W'($urandom_range(3, 255)), $urandom());
            end
            for (int k = 0; k < pool_n; k++)
            begin
                pool[k] = $urandom();
            end
            now_s = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFC0 + $urandom_range(0, 63)
                                                : $urandom();
            len = (pool_n == 1) ? 130 : $urandom_range(40, 120);
            for (int j = 0; j < len; j++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    now_s = now_s + $urandom_range(0, 200);
                end
                else
                begin
                    now_s = now_s + $urandom_range(0, 2);
                end
                pick = $urandom_range(0, 15);
                if (pool_n == 70 && j < 70)
                begin
                    push_report(pool[j], now_s);
                end
                else if (pick < 2)
                begin
                    push_sweep(now_s);
                end
                else if (pick == 2)
                begin
                    push_report($urandom(), now_s);
                end
                else
                begin
                    push_report(pool[$urandom_range(0, pool_n - 1)], now_s);
                end
            end
            total += len;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (work_q.size() != 0 || verdict_q.size() != 0 || start || cfg_valid)
        begin
            @(posedge clk);
        end
        repeat (SLOTS + 8) @(posedge clk);
        if (mismatches == 0 && verdict_q.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
